[rtl/core/olid_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package olid_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_INSERT   = 2'd0;
	localparam cmd_t CMD_DELETE   = 2'd1;
	localparam cmd_t CMD_TRAVERSE = 2'd2;
	localparam cmd_t CMD_NONE     = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t ST_INSERTED = 3'd0;
	localparam status_t ST_DELETED  = 3'd1;
	localparam status_t ST_NOTFOUND = 3'd2;
	localparam status_t ST_EMPTY    = 3'd3;
	localparam status_t ST_ENTRY    = 3'd4;
	localparam status_t ST_FULL     = 3'd5;

	typedef logic [1:0] op_t;
	localparam op_t OP_HOLD   = 2'd0;
	localparam op_t OP_INSERT = 2'd1;
	localparam op_t OP_ROTATE = 2'd2;
	localparam op_t OP_DROP   = 2'd3;

	typedef logic [1:0] sel_t;
	localparam sel_t SEL_VALUE = 2'd0;
	localparam sel_t SEL_HEAD  = 2'd1;
	localparam sel_t SEL_ZERO  = 2'd2;

	typedef struct packed {
		logic    load;
		op_t     op;
		logic    emit;
		sel_t    sel;
		status_t status;
		logic    last;
	} ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             full;
		logic             match;
	} stat_t;

endpackage

`default_nettype wire

[rtl/core/olid_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module olid_dp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire signed [31:0]            value,
	input  olid_pkg::ctrl_t              ctrl,
	output olid_pkg::stat_t              stat,
	output logic                         valid,
	output logic signed [31:0]           item_value,
	output olid_pkg::status_t            status,
	output logic                         last
);
	import olid_pkg::*;

	logic [VAL_W-1:0] entries_q [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] last_idx;
	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] item_q;
	status_t          status_q;
	logic             last_q;
	logic             valid_q;

	assign last_idx    = count_q - CNT_W'(1);
	assign stat.count  = count_q;
	assign stat.full   = (count_q == CNT_W'(DEPTH));
	assign stat.match  = (entries_q[0] == value_q);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			value_q <= value;
		end
		for (int j = 0; j < DEPTH; j++) begin
			case (ctrl.op)
				OP_INSERT: begin
					if (j == 0) begin
						entries_q[j] <= value_q;
					end else begin
						entries_q[j] <= entries_q[j-1];
					end
				end
				OP_ROTATE: begin
					if (CNT_W'(j) == last_idx) begin
						entries_q[j] <= entries_q[0];
					end else if (j < DEPTH - 1) begin
						entries_q[j] <= entries_q[(j+1) % DEPTH];
					end
				end
				OP_DROP: begin
					if (j < DEPTH - 1) begin
						entries_q[j] <= entries_q[(j+1) % DEPTH];
					end
				end
				default: begin
				end
			endcase
		end
		if (ctrl.emit) begin
			case (ctrl.sel)
				SEL_HEAD: item_q <= entries_q[0];
				SEL_ZERO: item_q <= '0;
				default:  item_q <= value_q;
			endcase
			status_q <= ctrl.status;
			last_q   <= ctrl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= ctrl.emit;
			if (ctrl.op == OP_INSERT) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.op == OP_DROP) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign valid      = valid_q;
	assign item_value = item_q;
	assign status     = status_q;
	assign last       = last_q;

endmodule

`default_nettype wire

[rtl/core/olid_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module olid_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire [1:0]          cmd,
	input  olid_pkg::stat_t    stat,
	output logic               busy,
	output olid_pkg::ctrl_t    ctrl
);
	import olid_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic             state_q;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] rem_q;
	logic             found_q;
	logic             accept;
	logic             done;
	logic             hit;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign hit    = stat.match && !found_q;

	always_comb begin
		ctrl        = '0;
		ctrl.op     = OP_HOLD;
		ctrl.sel    = SEL_VALUE;
		ctrl.status = ST_EMPTY;
		ctrl.load   = accept;
		done        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_RUN: begin
				unique case (cmd_q)
					CMD_INSERT: begin
						ctrl.emit   = 1'b1;
						ctrl.last   = 1'b1;
						ctrl.status = stat.full ? ST_FULL : ST_INSERTED;
						ctrl.op     = stat.full ? OP_HOLD : OP_INSERT;
						done        = 1'b1;
					end
					CMD_DELETE: begin
						if (rem_q == '0) begin
							ctrl.emit = 1'b1;
							ctrl.last = 1'b1;
							done      = 1'b1;
						end else begin
							ctrl.op = hit ? OP_DROP : OP_ROTATE;
							if (rem_q == CNT_W'(1)) begin
								ctrl.emit   = 1'b1;
								ctrl.last   = 1'b1;
								ctrl.status = (found_q || hit) ? ST_DELETED : ST_NOTFOUND;
								done        = 1'b1;
							end
						end
					end
					CMD_TRAVERSE: begin
						ctrl.emit = 1'b1;
						if (rem_q == '0) begin
							ctrl.sel  = SEL_ZERO;
							ctrl.last = 1'b1;
							done      = 1'b1;
						end else begin
							ctrl.op     = OP_ROTATE;
							ctrl.sel    = SEL_HEAD;
							ctrl.status = ST_ENTRY;
							ctrl.last   = (rem_q == CNT_W'(1));
							done        = (rem_q == CNT_W'(1));
						end
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_NONE;
			rem_q   <= '0;
			found_q <= 1'b0;
		end else if (accept) begin
			cmd_q   <= cmd;
			rem_q   <= stat.count;
			found_q <= 1'b0;
			state_q <= (cmd == CMD_NONE) ? S_IDLE : S_RUN;
		end else if (state_q == S_RUN) begin
			if (rem_q != '0) begin
				rem_q <= rem_q - CNT_W'(1);
			end
			found_q <= found_q || (ctrl.op == OP_DROP);
			if (done) begin
				state_q <= S_IDLE;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/ordered_list_insert_delete.sv]
// Sequence: an accepted item is registered into the controller, which then steps its run state;
// each result it emits is registered in the datapath before it is shown on the outputs.
// An insert takes one run step; a delete or traverse takes one step per entry (one for an
// empty list), with one rotation step of the entry shift line per cycle; a new item is taken
// in the cycle its last result is shown. Results cannot be stalled by the receiver.
// Reset: arst_n clears the list to empty and drops busy and valid; entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_delete (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire [1:0]          cmd,
	input  wire signed [31:0]  value,
	output logic               busy,
	output logic               valid,
	output logic signed [31:0] item_value,
	output logic [2:0]         status,
	output logic               last
);
	import olid_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	olid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	olid_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.ctrl       (ctrl),
		.stat       (stat),
		.valid      (valid),
		.item_value (item_value),
		.status     (status),
		.last       (last)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != ST_ENTRY |-> last)
		else $error("single result without last");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> valid && last)
		else $error("item ended without final result");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("intermediate result while idle");

endmodule

`default_nettype wire

[tb/olid_list_checker.sv]
`timescale 1ns / 1ps

module olid_list_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire         busy,
	input  wire [1:0]   cmd,
	input  wire [31:0]  value,
	input  wire         valid,
	input  wire [31:0]  item_value,
	input  wire [2:0]   status,
	input  wire         last,
	output int          errors,
	output int          pending
);
	import olid_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0] val;
		status_t          st;
		logic             fin;
	} list_result_t;

	list_result_t     due_results[$];
	logic [VAL_W-1:0] shadow_list[DEPTH];
	int               shadow_len;
	list_result_t     want;
	list_result_t     got;

	task automatic predict_command(input cmd_t c, input logic [VAL_W-1:0] v);
		int hit;
		hit = -1;
		case (c)
			CMD_INSERT: begin
				if (shadow_len >= DEPTH) begin
					due_results.push_back({v, ST_FULL, 1'b1});
				end else begin
					for (int i = shadow_len; i > 0; i--)
						shadow_list[i] = shadow_list[i - 1];
					shadow_list[0] = v;
					shadow_len++;
					due_results.push_back({v, ST_INSERTED, 1'b1});
				end
			end
			CMD_DELETE: begin
				if (shadow_len == 0) begin
					due_results.push_back({v, ST_EMPTY, 1'b1});
				end else begin
					for (int i = 0; i < shadow_len; i++)
						if (hit < 0 && shadow_list[i] == v)
							hit = i;
					if (hit < 0) begin
						due_results.push_back({v, ST_NOTFOUND, 1'b1});
					end else begin
						for (int j = hit; j + 1 < shadow_len; j++)
							shadow_list[j] = shadow_list[j + 1];
						shadow_len--;
						due_results.push_back({v, ST_DELETED, 1'b1});
					end
				end
			end
			CMD_TRAVERSE: begin
				if (shadow_len == 0) begin
					due_results.push_back({{VAL_W{1'b0}}, ST_EMPTY, 1'b1});
				end else begin
					for (int i = 0; i < shadow_len; i++)
						due_results.push_back({shadow_list[i], ST_ENTRY,
							(i == shadow_len - 1) ? 1'b1 : 1'b0});
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			shadow_len = 0;
			errors = 0;
			pending = 0;
		end else begin
			if (valid) begin
				got = {item_value, status, last};
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: result with none due: item_value %h status %0d last %0d",
						$time, item_value, status, last);
				end else begin
					want = due_results.pop_front();
					if (got.val !== want.val || got.st !== want.st || got.fin !== want.fin) begin
						errors++;
						$display("%0t: expected item_value %h status %0d last %0d, got %h %0d %0d",
							$time, want.val, want.st, want.fin, got.val, got.st, got.fin);
					end
				end
			end
			if (start && !busy)
				predict_command(cmd_t'(cmd), value);
			pending = due_results.size();
		end
	end

endmodule

[tb/tb_ordered_list_insert_delete.sv]
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete;
	import olid_pkg::*;

	localparam int RANDOM_ITEMS = 420;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = DEPTH + 4;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	cmd_t               cmd = CMD_INSERT;
	logic signed [31:0] value = '0;
	wire                busy;
	wire                valid;
	wire signed [31:0]  item_value;
	wire [2:0]          status;
	wire                last;

	int          errors;
	int          pending;
	int          quiet_cycles = 0;
	logic        no_gaps = 1'b0;
	logic [31:0] value_pool[8];
	logic [31:0] recent_inserts[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ordered_list_insert_delete DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.value      (value),
		.busy       (busy),
		.valid      (valid),
		.item_value (item_value),
		.status     (status),
		.last       (last)
	);

	olid_list_checker list_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.value      (value),
		.valid      (valid),
		.item_value (item_value),
		.status     (status),
		.last       (last),
		.errors     (errors),
		.pending    (pending)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || valid)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_ordered_list_insert_delete: errors");
				$finish;
			end
		end
	end

	function automatic logic [31:0] pick_value();
		if ($urandom_range(99) < 65)
			return value_pool[$urandom_range(7)];
		return $urandom();
	endfunction

	task automatic send_item(input cmd_t c, input logic [31:0] v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(8);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd   <= c;
		value <= v;
		do @(posedge clk); while (busy);
		if (c == CMD_INSERT) begin
			recent_inserts.push_back(v);
			if (recent_inserts.size() > 32)
				void'(recent_inserts.pop_front());
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int          sent;
		int          n;
		int          r;
		int          phase;
		int          ins_lim;
		int          del_lim;
		cmd_t        c;
		logic [31:0] v;

		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		send_item(CMD_TRAVERSE, 32'h0);
		send_item(CMD_DELETE, 32'h8000_0000);
		send_item(CMD_NONE, 32'hffff_ffff);
		send_item(CMD_INSERT, 32'h0000_0005);
		send_item(CMD_DELETE, 32'h0000_0005);
		for (int i = 0; i < DEPTH; i++)
			send_item(CMD_INSERT, (i < 4) ? value_pool[i] : (i == 6) ? value_pool[0] : $urandom());
		send_item(CMD_INSERT, 32'h7fff_ffff);
		send_item(CMD_TRAVERSE, 32'hffff_ffff);
		send_item(CMD_DELETE, 32'h0000_0002);
		send_item(CMD_DELETE, value_pool[0]);
		send_item(CMD_DELETE, value_pool[0]);
		send_item(CMD_TRAVERSE, 32'h0);
		drain();

		sent = 0;
		n = 0;
		while (sent < RANDOM_ITEMS) begin
			if (n % 35 == 0) begin
				phase = (n / 35) % 3;
				no_gaps = ($urandom_range(3) == 0);
			end
			if (n % 70 == 69)
				drain();
			ins_lim = (phase == 0) ? 65 : (phase == 1) ? 15 : 40;
			del_lim = (phase == 2) ? 75 : 80;
			r = $urandom_range(99);
			if (r < ins_lim)
				c = CMD_INSERT;
			else if (r < del_lim)
				c = CMD_DELETE;
			else if (r < 97)
				c = CMD_TRAVERSE;
			else
				c = CMD_NONE;
			if (c == CMD_DELETE && recent_inserts.size() > 0 && $urandom_range(99) < 70)
				v = recent_inserts[$urandom_range(recent_inserts.size() - 1)];
			else
				v = pick_value();
			send_item(c, v);
			if (c != CMD_NONE)
				sent++;
			n++;
		end

		@(negedge clk);
		start <= 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_ordered_list_insert_delete: clean");
		else
			$display("tb_ordered_list_insert_delete: errors");
		$finish;
	end

endmodule
